// ----- design/dwtp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwtp_pkg
// Shared types, character codes and decode helpers for the wire token parser.
// ----------------------------------------------------------------------------
package dwtp_pkg;

  localparam int CntW = 21;
  localparam int RefW = 20;

  // token kinds
  localparam logic [1:0] KIND_TERM = 2'd0;
  localparam logic [1:0] KIND_LIT  = 2'd1;
  localparam logic [1:0] KIND_APP  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR = 3'd1;
  localparam logic [2:0] ST_BAD_HEX  = 3'd2;
  localparam logic [2:0] ST_BAD_APP  = 3'd3;
  localparam logic [2:0] ST_BAD_REF  = 3'd4;
  localparam logic [2:0] ST_TOO_MANY = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  // hex digit classes
  localparam logic [1:0] HC_NONE  = 2'd0;
  localparam logic [1:0] HC_DIGIT = 2'd1;
  localparam logic [1:0] HC_UPPER = 2'd2;
  localparam logic [1:0] HC_LOWER = 2'd3;

  localparam logic [3:0] SYM_NONE = 4'd15;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [CntW-1:0] AccMax = {CntW{1'b1}};
  localparam logic [RefW-1:0] RefMax = {RefW{1'b1}};

  // one result beat
  typedef struct packed {
    logic [1:0]      kind;
    logic [3:0]      sym;
    logic [7:0]      lit;
    logic [RefW-1:0] left;
    logic [RefW-1:0] right;
    logic [RefW-1:0] number;
    logic [CntW-1:0] total;
    logic [2:0]      status;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       is_tok;
    logic [3:0] sym;
    logic       go_u;
    logic       go_at;
    logic       bad;
  } idle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [3:0] term_code(input logic [7:0] c);
    logic [3:0] s;
    unique case (c)
      8'h53:    s = 4'd0;   // S
      8'h4B:    s = 4'd1;   // K
      8'h49:    s = 4'd2;   // I
      8'h42:    s = 4'd3;   // B
      8'h43:    s = 4'd4;   // C
      8'h50:    s = 4'd5;   // P
      8'h51:    s = 4'd6;   // Q
      8'h52:    s = 4'd7;   // R
      CH_COMMA: s = 4'd8;
      CH_DOT:   s = 4'd9;
      8'h45:    s = 4'd10;  // E
      default:  s = SYM_NONE;
    endcase
    return s;
  endfunction

  function automatic hex_t hex_class(input logic [7:0] c);
    hex_t h;
    h.cls = HC_NONE;
    h.val = 4'd0;
    if (is_digit(c)) begin
      h.cls = HC_DIGIT;
      h.val = c[3:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.cls = HC_UPPER;
      h.val = 4'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      h.cls = HC_LOWER;
      h.val = 4'(c - CH_LA + 8'd10);
    end
    return h;
  endfunction

  // what a byte does between tokens
  function automatic idle_t idle_decode(input logic [7:0] c);
    idle_t d;
    logic [3:0] s;
    s = term_code(c);
    d = '0;
    d.sym = s;
    if (!is_space(c)) begin
      if (s != SYM_NONE) d.is_tok = 1'b1;
      else if (c == CH_U) d.go_u = 1'b1;
      else if (c == CH_AT) d.go_at = 1'b1;
      else d.bad = 1'b1;
    end
    return d;
  endfunction

  // decimal accumulate with saturation
  function automatic logic [CntW-1:0] acc_step(input logic [CntW-1:0] acc,
                                               input logic [7:0] c);
    logic [CntW+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{CntW{1'b0}}, c[3:0]};
    return (v > {4'b0, AccMax}) ? AccMax : v[CntW-1:0];
  endfunction

  function automatic logic [RefW-1:0] sat_ref(input logic [CntW-1:0] acc);
    return acc[CntW-1] ? RefMax : acc[RefW-1:0];
  endfunction

  function automatic res_t make_tok(input logic [1:0] kind, input logic [3:0] sym,
                                    input logic [7:0] lit, input logic [RefW-1:0] l,
                                    input logic [RefW-1:0] r,
                                    input logic [CntW-1:0] num);
    res_t t;
    t = '0;
    t.kind   = kind;
    t.sym    = sym;
    t.lit    = lit;
    t.left   = l;
    t.right  = r;
    t.number = num[RefW-1:0];
    return t;
  endfunction

endpackage

// ----- design/dwtp_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwtp_parse
// Scanner state and per-byte decode: turns one registered byte into up to
// three result beats and the next scanner state.
// ----------------------------------------------------------------------------
module dwtp_parse #(
  parameter int MAX_TOKENS = 1048576
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  output dwtp_pkg::res_t      slots [3],
  output logic [1:0]          count
);
  import dwtp_pkg::*;

  localparam logic [CntW-1:0] MaxTok = CntW'(MAX_TOKENS);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_U1, PH_U2_DIG, PH_U2_UP, PH_U2_LO,
    PH_PRE_L, PH_AT_L, PH_POST_L, PH_PRE_R, PH_AT_R
  } phase_t;

  phase_t          phase, phase_next;
  logic [3:0]      hex_hi, hex_hi_next;
  logic [CntW-1:0] acc, acc_next;
  logic [RefW-1:0] left_held, left_held_next;
  logic [CntW-1:0] tok_cnt, tok_cnt_next;
  logic [2:0]      err, err_next;

  res_t       slots_w [3];
  logic [1:0] n_w;
  logic [2:0] chk;
  hex_t       hc;
  idle_t      id;

  // reasons a token cannot be emitted
  function automatic logic [2:0] emit_check(input logic [1:0] kind,
                                            input logic [RefW-1:0] l,
                                            input logic [CntW-1:0] r,
                                            input logic [CntW-1:0] cnt);
    logic [2:0] code;
    code = ST_OK;
    if (cnt >= MaxTok) code = ST_TOO_MANY;
    else if (kind == KIND_APP && ({1'b0, l} >= cnt || r >= cnt)) code = ST_BAD_REF;
    return code;
  endfunction

  // per-byte decode
  always_comb begin
    phase_next     = phase;
    hex_hi_next    = hex_hi;
    acc_next       = acc;
    left_held_next = left_held;
    tok_cnt_next   = tok_cnt;
    err_next       = err;
    n_w            = 2'd0;
    chk            = ST_OK;
    hc             = hex_class(text_byte);
    id             = idle_decode(text_byte);
    for (int i = 0; i < 3; i++) slots_w[i] = '0;

    if (err == ST_OK) begin
      unique case (phase)
        PH_U1: begin
          if (hc.cls == HC_NONE) err_next = ST_BAD_HEX;
          else begin
            hex_hi_next = hc.val;
            unique case (hc.cls)
              HC_DIGIT: phase_next = PH_U2_DIG;
              HC_UPPER: phase_next = PH_U2_UP;
              default:  phase_next = PH_U2_LO;
            endcase
          end
        end
        PH_U2_DIG, PH_U2_UP, PH_U2_LO: begin
          if (hc.cls == HC_NONE || (phase == PH_U2_UP && hc.cls == HC_LOWER) ||
              (phase == PH_U2_LO && hc.cls == HC_UPPER)) begin
            err_next = ST_BAD_HEX;
          end else begin
            phase_next = PH_IDLE;
            chk = emit_check(KIND_LIT, '0, '0, tok_cnt_next);
            if (chk == ST_OK) begin
              slots_w[n_w] = make_tok(KIND_LIT, 4'd0, {hex_hi, hc.val}, '0, '0,
                                      tok_cnt_next);
              n_w = n_w + 2'd1;
              tok_cnt_next = tok_cnt_next + CntOne;
            end else err_next = chk;
          end
        end
        PH_PRE_L, PH_PRE_R: begin
          if (is_digit(text_byte)) begin
            acc_next   = {{(CntW-4){1'b0}}, text_byte[3:0]};
            phase_next = (phase == PH_PRE_L) ? PH_AT_L : PH_AT_R;
          end else if (!is_space(text_byte)) err_next = ST_BAD_APP;
        end
        PH_AT_L: begin
          if (is_digit(text_byte)) acc_next = acc_step(acc, text_byte);
          else if (is_space(text_byte)) begin
            left_held_next = sat_ref(acc);
            phase_next     = PH_POST_L;
          end else if (text_byte == CH_COMMA) begin
            left_held_next = sat_ref(acc);
            phase_next     = PH_PRE_R;
          end else err_next = ST_BAD_APP;
        end
        PH_POST_L: begin
          if (text_byte == CH_COMMA) phase_next = PH_PRE_R;
          else if (!is_space(text_byte)) err_next = ST_BAD_APP;
        end
        PH_AT_R: begin
          if (is_digit(text_byte)) acc_next = acc_step(acc, text_byte);
          else begin
            // application ends here, then the byte is scanned afresh
            phase_next = PH_IDLE;
            chk = emit_check(KIND_APP, left_held, acc, tok_cnt_next);
            if (chk == ST_OK) begin
              slots_w[n_w] = make_tok(KIND_APP, 4'd0, 8'd0, left_held,
                                      acc[RefW-1:0], tok_cnt_next);
              n_w = n_w + 2'd1;
              tok_cnt_next = tok_cnt_next + CntOne;
            end else err_next = chk;
            if (err_next == ST_OK) begin
              if (id.is_tok) begin
                chk = emit_check(KIND_TERM, '0, '0, tok_cnt_next);
                if (chk == ST_OK) begin
                  slots_w[n_w] = make_tok(KIND_TERM, id.sym, 8'd0, '0, '0,
                                          tok_cnt_next);
                  n_w = n_w + 2'd1;
                  tok_cnt_next = tok_cnt_next + CntOne;
                end else err_next = chk;
              end else if (id.go_u) phase_next = PH_U1;
              else if (id.go_at) phase_next = PH_PRE_L;
              else if (id.bad) err_next = ST_BAD_CHAR;
            end
          end
        end
        default: begin
          // idle between tokens
          phase_next = PH_IDLE;
          if (id.is_tok) begin
            chk = emit_check(KIND_TERM, '0, '0, tok_cnt_next);
            if (chk == ST_OK) begin
              slots_w[n_w] = make_tok(KIND_TERM, id.sym, 8'd0, '0, '0, tok_cnt_next);
              n_w = n_w + 2'd1;
              tok_cnt_next = tok_cnt_next + CntOne;
            end else err_next = chk;
          end else if (id.go_u) phase_next = PH_U1;
          else if (id.go_at) phase_next = PH_PRE_L;
          else if (id.bad) err_next = ST_BAD_CHAR;
        end
      endcase
    end

    // end of buffer: close open token and report status
    if (final_byte) begin
      if (err_next == ST_OK) begin
        if (phase_next == PH_AT_R) begin
          chk = emit_check(KIND_APP, left_held_next, acc_next, tok_cnt_next);
          if (chk == ST_OK) begin
            slots_w[n_w] = make_tok(KIND_APP, 4'd0, 8'd0, left_held_next,
                                    acc_next[RefW-1:0], tok_cnt_next);
            n_w = n_w + 2'd1;
            tok_cnt_next = tok_cnt_next + CntOne;
          end else err_next = chk;
        end else if (phase_next == PH_U1 || phase_next == PH_U2_DIG ||
                     phase_next == PH_U2_UP || phase_next == PH_U2_LO) begin
          err_next = ST_BAD_HEX;
        end else if (phase_next != PH_IDLE) begin
          err_next = ST_BAD_APP;
        end
      end
      if (err_next == ST_OK && tok_cnt_next == '0) err_next = ST_EMPTY;
      slots_w[n_w]        = '0;
      slots_w[n_w].kind   = KIND_END;
      slots_w[n_w].total  = tok_cnt_next;
      slots_w[n_w].status = err_next;
      if (err_next == ST_OK) slots_w[n_w].number = RefW'(tok_cnt_next - CntOne);
      n_w = n_w + 2'd1;
      phase_next     = PH_IDLE;
      hex_hi_next    = '0;
      acc_next       = '0;
      left_held_next = '0;
      tok_cnt_next   = '0;
      err_next       = ST_OK;
    end

    // mark the last beat of this byte
    if (n_w != 2'd0) slots_w[n_w - 2'd1].last = 1'b1;
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hex_hi    <= '0;
      acc       <= '0;
      left_held <= '0;
      tok_cnt   <= '0;
      err       <= ST_OK;
    end else if (take) begin
      phase     <= phase_next;
      hex_hi    <= hex_hi_next;
      acc       <= acc_next;
      left_held <= left_held_next;
      tok_cnt   <= tok_cnt_next;
      err       <= err_next;
    end
  end

  assign slots = slots_w;
  assign count = n_w;

endmodule

// ----- design/dwtp_result_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwtp_result_buf
// Three-entry result register: loads all beats of one byte at once and
// drains them one beat a cycle on the master side while out_ready is high.
// ----------------------------------------------------------------------------
module dwtp_result_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  dwtp_pkg::res_t load_slots [3],
  input  logic [1:0]     load_count,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output dwtp_pkg::res_t out_beat
);
  import dwtp_pkg::*;

  res_t       q [3];
  logic [1:0] fill;
  logic       pop;

  // accept a new byte once at most the beat leaving now remains
  assign out_valid = (fill != 2'd0);
  assign pop       = out_valid && out_ready;
  assign can_load  = (fill == 2'd0) || (fill == 2'd1 && pop);
  assign out_beat  = q[0];

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (load) begin
      fill <= load_count;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  // beat storage, head at entry 0
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_slots;
    end else if (pop) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

endmodule

// ----- design/dag_wire_token_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_wire_token_parser
// Tokenizer for a DAG wire text, one byte a beat, tokens and status out.
// ----------------------------------------------------------------------------
// The byte is held in the input register, then decoded into the result register
// once that register can load it, which makes the first result beat valid.
// Throughput: one byte per cycle while each byte yields at most one beat and
// m_tready is high; a byte yielding more beats holds the result register until all drain.
// Reset (rst, synchronous) returns the scanner to idle between tokens, clears
// the token count and error, and empties both registers.
module dag_wire_token_parser #(
  parameter int MAX_TOKENS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // symbol_code, literal_value, left_ref, right_ref,
                                 // token_number, token_total, status_code
  output logic [1:0]  m_tuser,   // token_kind
  output logic        m_tlast    // run_end
);
  import dwtp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_final;
  logic       take;
  logic       can_load;
  res_t       slots [3];
  logic [1:0] count;
  res_t       beat;

  assign take     = in_valid && can_load;
  assign s_tready = !in_valid || take;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  dwtp_parse #(
    .MAX_TOKENS(MAX_TOKENS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .text_byte  (in_byte),
    .final_byte (in_final),
    .slots      (slots),
    .count      (count)
  );

  dwtp_result_buf u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .load_slots (slots),
    .load_count (count),
    .can_load   (can_load),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_beat   (beat)
  );

  // pack the beat
  assign m_tdata = {beat.status, beat.total, beat.number, beat.right, beat.left,
                    beat.lit, beat.sym};
  assign m_tuser = beat.kind;
  assign m_tlast = beat.last;

endmodule
